// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/crcfr_pkg.sv -----
// types, codes and crc function of the crc32 frame receiver
// no dependencies
`default_nettype none

package crcfr_pkg;

	localparam int TRAILER_LEN = 4;
	localparam int POS_W       = 3;
	localparam logic [POS_W-1:0] POS_TRAILER = POS_W'(TRAILER_LEN);
	localparam logic [POS_W-1:0] POS_MAX     = 3'd6;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_TYPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE    = 1'b1;
	localparam logic [7:0] CONTROL_TYPE_RESET = 8'd0;
	localparam logic [7:0] DATA_TYPE_RESET    = 8'd1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
	localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

	localparam logic [1:0] ROUTE_DATA    = 2'd0;
	localparam logic [1:0] ROUTE_CONTROL = 2'd1;
	localparam logic [1:0] ROUTE_FAILURE = 2'd2;
	localparam logic [1:0] ROUTE_DROPPED = 2'd3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_byte;
		logic [7:0] msg_id;
		logic [1:0] status;
		logic [1:0] route;
		logic       end_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	typedef struct packed {
		logic                  room;
		logic [FIFO_CNT_W-1:0] count;
	} fifo_stat_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crcfr_if.sv -----
// valid/ready stream interfaces for frame bytes and result items
// no dependencies
`default_nettype none

interface crcfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcfr_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [7:0] msg_id;
	logic [1:0] status;
	logic [1:0] route;
	logic       end_of_run;

	modport source (output valid, output result_kind, output payload_byte,
		output msg_id, output status, output route, output end_of_run,
		input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input msg_id, input status, input route, input end_of_run,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/crcfr_deframer.sv -----
// input register, frame state, crc check and result generation
// depends on crcfr_pkg and crcfr_if
`default_nettype none

module crcfr_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	crcfr_in_if.sink                            frames,
	input  crcfr_pkg::fifo_stat_t               fifo_stat,
	output crcfr_pkg::push_t                    push
);
	import crcfr_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             fire;

	logic [7:0]       control_type_q;
	logic [7:0]       data_type_q;

	logic [31:0]      crc_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       delay_q [TRAILER_LEN];
	logic [7:0]       type_q;
	logic [7:0]       tid_q;

	logic [31:0]      crc_next;
	logic [7:0]       leaving;
	logic [31:0]      recv;
	logic             pay_valid;
	logic             verdict_valid;
	logic             is_ctrl;
	result_t          pay_res;
	result_t          verdict_res;

	assign fire         = valid_s1 && fifo_stat.room;
	assign frames.ready = !valid_s1 || fifo_stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			byte_s1 <= frames.data_byte;
			last_s1 <= frames.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_type_q <= CONTROL_TYPE_RESET;
			data_type_q    <= DATA_TYPE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_CONTROL_TYPE: control_type_q <= cfg_data;
				CFG_DATA_TYPE:    data_type_q    <= cfg_data;
			endcase
		end
	end

	assign leaving       = delay_q[0];
	assign crc_next      = (pos_q >= POS_TRAILER) ? crc_feed(crc_q, leaving) : crc_q;
	assign recv          = {delay_q[1], delay_q[2], delay_q[3], byte_s1};
	assign pay_valid     = (pos_q == POS_MAX);
	assign verdict_valid = last_s1 && (pos_q >= POS_TRAILER);
	assign is_ctrl       = (type_q == control_type_q);

	always_comb begin
		pay_res              = '0;
		pay_res.result_kind  = KIND_PAYLOAD;
		pay_res.payload_byte = leaving;
		pay_res.msg_id       = tid_q;
		pay_res.end_of_run   = !last_s1;

		verdict_res             = '0;
		verdict_res.result_kind = KIND_VERDICT;
		verdict_res.msg_id      = tid_q;
		verdict_res.end_of_run  = 1'b1;
		priority if (~crc_next != recv) begin
			verdict_res.status = STATUS_CRC_BAD;
			verdict_res.route  = is_ctrl ? ROUTE_DROPPED : ROUTE_FAILURE;
		end else if (is_ctrl) begin
			verdict_res.status = STATUS_OK;
			verdict_res.route  = ROUTE_CONTROL;
		end else if (type_q == data_type_q) begin
			verdict_res.status = STATUS_OK;
			verdict_res.route  = ROUTE_DATA;
		end else begin
			verdict_res.status = STATUS_BAD_TYPE;
			verdict_res.route  = ROUTE_FAILURE;
		end
	end

	always_comb begin
		push.count  = fire ? ({1'b0, pay_valid} + {1'b0, verdict_valid}) : 2'd0;
		push.first  = pay_valid ? pay_res : verdict_res;
		push.second = verdict_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			pos_q  <= '0;
			type_q <= '0;
			tid_q  <= '0;
			for (int i = 0; i < TRAILER_LEN; i++) begin
				delay_q[i] <= '0;
			end
		end else if (fire) begin
			if (last_s1) begin
				crc_q  <= CRC_INIT;
				pos_q  <= '0;
				type_q <= '0;
				tid_q  <= '0;
				for (int i = 0; i < TRAILER_LEN; i++) begin
					delay_q[i] <= '0;
				end
			end else begin
				crc_q <= crc_next;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				if (pos_q == '0) begin
					type_q <= byte_s1;
				end
				if (pos_q == POS_W'(1)) begin
					tid_q <= byte_s1;
				end
				for (int i = 0; i < TRAILER_LEN - 1; i++) begin
					delay_q[i] <= delay_q[i + 1];
				end
				delay_q[TRAILER_LEN - 1] <= byte_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crcfr_result_fifo.sv -----
// small result queue, takes up to two results a cycle, gives one
// depends on crcfr_pkg and crcfr_if
`default_nettype none

module crcfr_result_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crcfr_pkg::push_t        push,
	output crcfr_pkg::fifo_stat_t   fifo_stat,
	crcfr_out_if.source             results
);
	import crcfr_pkg::*;

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_1;
	logic                  pop;
	result_t               head;

	assign wr_ptr_1 = wr_ptr_q + 1'b1;
	assign pop      = results.valid && results.ready;
	assign head     = mem_q[rd_ptr_q];

	assign fifo_stat.room  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign fifo_stat.count = count_q;

	assign results.valid        = (count_q != '0);
	assign results.result_kind  = head.result_kind;
	assign results.payload_byte = head.payload_byte;
	assign results.msg_id       = head.msg_id;
	assign results.status       = head.status;
	assign results.route        = head.route;
	assign results.end_of_run   = head.end_of_run;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crc32_frame_receiver.sv -----
// top level of the crc32 frame receiver
// depends on crcfr_pkg, crcfr_if, crcfr_deframer, crcfr_result_fifo, assert_macros.svh
//
// channel   dir   transaction
// frames    in    one frame byte with its last-byte mark
// results   out   one payload byte or one end-of-frame verdict
// cfg       in    write of a type code register, no handshake
//
// one byte a cycle sustained while the queue has room; a byte waits in the input register,
// then its results land in a four-entry queue and show the next cycle
// the last byte of a frame of seven or more bytes gives two results, so the
// queue takes in more results than it can give out at each frame end
// reset clears frame state and the queue, loads type code defaults; no clearing pass
// a stalled result side fills the queue, then holds the input register and ready
`default_nettype none
`include "assert_macros.svh"

module crc32_frame_receiver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	crcfr_in_if.sink                            frames,
	crcfr_out_if.source                         results
);
	import crcfr_pkg::*;

	push_t      push;
	fifo_stat_t fifo_stat;

	crcfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frames    (frames),
		.fifo_stat (fifo_stat),
		.push      (push)
	);

	crcfr_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.fifo_stat (fifo_stat),
		.results   (results)
	);

	`ASSERT_ALWAYS(a_fifo_bound, clk, arst_n, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
	`ASSERT_IMPLY(a_push_room, clk, arst_n, push.count != 2'd0, fifo_stat.room)
	`ASSERT_IMPLY(a_pair_order, clk, arst_n, push.count == 2'd2, push.first.result_kind == KIND_PAYLOAD && push.second.result_kind == KIND_VERDICT)
	`ASSERT_IMPLY(a_verdict_ends, clk, arst_n, results.valid && results.result_kind == KIND_VERDICT, results.end_of_run && results.payload_byte == 8'd0)

endmodule

`default_nettype wire
